>>> sv/onb_pkg.sv
// onb_pkg: shared types and constants for the octant neighbor burial block.
// Used by onb_front, onb_queue, onb_back and octant_neighbor_burial.
package onb_pkg;

    localparam int OCTANTS   = 8;
    localparam int OCT_W     = 3;
    localparam int COUNT_W   = 10;
    localparam int CUTOFF_W  = 16;
    localparam int LIM_W     = 2 * CUTOFF_W;
    localparam int CFG_ADDR_W = 2;

    localparam logic [COUNT_W-1:0]  COUNT_MAX    = 10'd1023;
    localparam logic [COUNT_W-1:0]  BURIED_MIN   = 10'd2;
    localparam logic [CUTOFF_W-1:0] CUTOFF_RESET = 16'd960;
    localparam logic [LIM_W-1:0]    LIM_RESET    = 32'd921600;

    // front-to-back queue
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;
    localparam int Q_CW    = 3;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_CENTER_X = 2'd0,
        REG_CENTER_Y = 2'd1,
        REG_CENTER_Z = 2'd2,
        REG_CUTOFF   = 2'd3
    } cfg_reg_t;

    // classified item handed from front to back
    typedef struct packed {
        logic             hit;
        logic [OCT_W-1:0] oct;
        logic             last;
    } class_t;

    typedef logic [COUNT_W-1:0] count_t;

endpackage

>>> sv/onb_front.sv
// onb_front: configuration registers and the two-stage classify pipeline
// (difference, square, distance compare). Depends on onb_pkg.
module onb_front #(
    parameter int COORD_WIDTH = 17,
    parameter int CFG_W       = 17
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [onb_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [CFG_W-1:0]                  cfg_wr_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [COORD_WIDTH-1:0]     s_nbr_x,
    input  logic signed [COORD_WIDTH-1:0]     s_nbr_y,
    input  logic signed [COORD_WIDTH-1:0]     s_nbr_z,
    input  logic                              s_is_self,
    input  logic                              s_last,
    output logic                              push,
    output onb_pkg::class_t                   push_data,
    input  logic                              q_full
);

    localparam int D     = COORD_WIDTH + 1;
    localparam int SQ_W  = 2 * D;
    localparam int SUM_W = (SQ_W + 2 > onb_pkg::LIM_W) ? SQ_W + 2 : onb_pkg::LIM_W;

    logic signed [COORD_WIDTH-1:0]      center_x_reg, center_y_reg, center_z_reg;
    logic [onb_pkg::CUTOFF_W-1:0]       cutoff_reg;
    logic [onb_pkg::LIM_W-1:0]          lim_reg;

    logic                               en;
    logic                               s1_valid_reg, s2_valid_reg;
    logic signed [D-1:0]                s1_dx_reg, s1_dy_reg, s1_dz_reg;
    logic [onb_pkg::OCT_W-1:0]          s1_oct_reg, s2_oct_reg;
    logic                               s1_self_reg, s2_self_reg;
    logic                               s1_last_reg, s2_last_reg;
    logic [SQ_W-1:0]                    s2_sqx_reg, s2_sqy_reg, s2_sqz_reg;

    logic signed [D-1:0]                dx, dy, dz;
    logic signed [SQ_W-1:0]             px, py, pz;
    logic [SUM_W-1:0]                   d2;
    logic [onb_pkg::LIM_W-1:0]          lim_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            center_z_reg <= '0;
            cutoff_reg   <= onb_pkg::CUTOFF_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                onb_pkg::REG_CENTER_X: center_x_reg <= cfg_wr_data[COORD_WIDTH-1:0];
                onb_pkg::REG_CENTER_Y: center_y_reg <= cfg_wr_data[COORD_WIDTH-1:0];
                onb_pkg::REG_CENTER_Z: center_z_reg <= cfg_wr_data[COORD_WIDTH-1:0];
                onb_pkg::REG_CUTOFF:   cutoff_reg   <= cfg_wr_data[onb_pkg::CUTOFF_W-1:0];
                default: ;
            endcase
        end
    end

    // squared limit is registered and follows the cutoff register in the cycle after
    assign lim_next = onb_pkg::LIM_W'(cutoff_reg) * onb_pkg::LIM_W'(cutoff_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lim_reg <= onb_pkg::LIM_RESET;
        end else begin
            lim_reg <= lim_next;
        end
    end

    // hold the whole pipeline while the last stage cannot enter the queue
    assign en      = !(s2_valid_reg && q_full);
    assign s_ready = en;

    assign dx = D'(s_nbr_x) - D'(center_x_reg);
    assign dy = D'(s_nbr_y) - D'(center_y_reg);
    assign dz = D'(s_nbr_z) - D'(center_z_reg);

    assign px = s1_dx_reg * s1_dx_reg;
    assign py = s1_dy_reg * s1_dy_reg;
    assign pz = s1_dz_reg * s1_dz_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= s_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_dx_reg   <= dx;
            s1_dy_reg   <= dy;
            s1_dz_reg   <= dz;
            // zero difference goes to the negative side
            s1_oct_reg  <= {(!dz[D-1] && (dz != '0)),
                            (!dy[D-1] && (dy != '0)),
                            (!dx[D-1] && (dx != '0))};
            s1_self_reg <= s_is_self;
            s1_last_reg <= s_last;
            s2_sqx_reg  <= px;
            s2_sqy_reg  <= py;
            s2_sqz_reg  <= pz;
            s2_oct_reg  <= s1_oct_reg;
            s2_self_reg <= s1_self_reg;
            s2_last_reg <= s1_last_reg;
        end
    end

    assign d2 = SUM_W'(s2_sqx_reg) + SUM_W'(s2_sqy_reg) + SUM_W'(s2_sqz_reg);

    assign push           = s2_valid_reg && !q_full;
    assign push_data.hit  = !s2_self_reg && (d2 < SUM_W'(lim_reg));
    assign push_data.oct  = s2_oct_reg;
    assign push_data.last = s2_last_reg;

endmodule

>>> sv/onb_queue.sv
// onb_queue: short FIFO of classified items between front and back.
// Depends on onb_pkg.
module onb_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  onb_pkg::class_t push_data,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output onb_pkg::class_t head
);

    onb_pkg::class_t            mem [onb_pkg::Q_DEPTH];
    logic [onb_pkg::Q_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [onb_pkg::Q_CW-1:0]   count_reg, count_next;

    assign full       = (count_reg == onb_pkg::Q_CW'(onb_pkg::Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full) else $error("push into full queue");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid) else $error("pop from empty queue");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= onb_pkg::Q_CW'(onb_pkg::Q_DEPTH)) else $error("queue count out of range");

endmodule

>>> sv/onb_back.sv
// onb_back: octant counters and the result register.
// Depends on onb_pkg.
module onb_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            head_valid,
    input  onb_pkg::class_t head,
    output logic            pop,
    output logic            m_valid,
    input  logic            m_ready,
    output onb_pkg::count_t m_count [onb_pkg::OCTANTS],
    output logic            m_buried
);

    onb_pkg::count_t cnt_reg  [onb_pkg::OCTANTS];
    onb_pkg::count_t cnt_inc  [onb_pkg::OCTANTS];
    onb_pkg::count_t out_reg  [onb_pkg::OCTANTS];
    logic            out_valid_reg;
    logic            buried_reg;
    logic            buried_next;
    logic            emit;

    // a last item waits only while an untaken result sits in the output register
    assign pop  = head_valid && (!head.last || !out_valid_reg || m_ready);
    assign emit = pop && head.last;

    always_comb begin
        buried_next = 1'b1;
        for (int i = 0; i < onb_pkg::OCTANTS; i++) begin
            cnt_inc[i] = cnt_reg[i];
            if (pop && head.hit && (head.oct == onb_pkg::OCT_W'(i))
                && (cnt_reg[i] != onb_pkg::COUNT_MAX)) begin
                cnt_inc[i] = cnt_reg[i] + 1'b1;
            end
            if (cnt_inc[i] < onb_pkg::BURIED_MIN) begin
                buried_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < onb_pkg::OCTANTS; i++) begin
                cnt_reg[i] <= '0;
            end
            out_valid_reg <= 1'b0;
        end else begin
            for (int i = 0; i < onb_pkg::OCTANTS; i++) begin
                cnt_reg[i] <= emit ? '0 : cnt_inc[i];
            end
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            for (int i = 0; i < onb_pkg::OCTANTS; i++) begin
                out_reg[i] <= cnt_inc[i];
            end
            buried_reg <= buried_next;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_count  = out_reg;
    assign m_buried = buried_reg;

    a_clear_after_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> (cnt_reg[0] == '0) && (cnt_reg[3] == '0) && (cnt_reg[7] == '0))
        else $error("counters not cleared after result");
    a_emit_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> m_valid) else $error("result not presented");
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !emit) else $error("untaken result overwritten");

endmodule

>>> sv/octant_neighbor_burial.sv
// Throughput: one item per cycle; the input stalls only when the 4-entry queue
// fills because a result waits on m_ready.
// Reset (synchronous, aresetn low): pipeline, queue and counters empty,
// center (0,0,0), cutoff 960.
// Top level: onb_front -> onb_queue -> onb_back. Depends on onb_pkg.
module octant_neighbor_burial #(
    parameter int COORD_WIDTH = 17
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [onb_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [((COORD_WIDTH > 16) ? COORD_WIDTH : 16)-1:0] cfg_wr_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [COORD_WIDTH-1:0]        s_nbr_x,
    input  logic signed [COORD_WIDTH-1:0]        s_nbr_y,
    input  logic signed [COORD_WIDTH-1:0]        s_nbr_z,
    input  logic                                 s_is_self,
    input  logic                                 s_last,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [onb_pkg::COUNT_W-1:0]          m_count_oct0,
    output logic [onb_pkg::COUNT_W-1:0]          m_count_oct1,
    output logic [onb_pkg::COUNT_W-1:0]          m_count_oct2,
    output logic [onb_pkg::COUNT_W-1:0]          m_count_oct3,
    output logic [onb_pkg::COUNT_W-1:0]          m_count_oct4,
    output logic [onb_pkg::COUNT_W-1:0]          m_count_oct5,
    output logic [onb_pkg::COUNT_W-1:0]          m_count_oct6,
    output logic [onb_pkg::COUNT_W-1:0]          m_count_oct7,
    output logic                                 m_buried
);

    localparam int CFG_W = (COORD_WIDTH > 16) ? COORD_WIDTH : 16;

    logic            push, q_full, pop, head_valid;
    onb_pkg::class_t push_data, head;
    onb_pkg::count_t counts [onb_pkg::OCTANTS];

    onb_front #(
        .COORD_WIDTH (COORD_WIDTH),
        .CFG_W       (CFG_W)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_nbr_x     (s_nbr_x),
        .s_nbr_y     (s_nbr_y),
        .s_nbr_z     (s_nbr_z),
        .s_is_self   (s_is_self),
        .s_last      (s_last),
        .push        (push),
        .push_data   (push_data),
        .q_full      (q_full)
    );

    onb_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_data  (push_data),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    onb_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_count    (counts),
        .m_buried   (m_buried)
    );

    assign m_count_oct0 = counts[0];
    assign m_count_oct1 = counts[1];
    assign m_count_oct2 = counts[2];
    assign m_count_oct3 = counts[3];
    assign m_count_oct4 = counts[4];
    assign m_count_oct5 = counts[5];
    assign m_count_oct6 = counts[6];
    assign m_count_oct7 = counts[7];

endmodule

>>> tb/octant_neighbor_burial_test.sv
`timescale 1ns / 1ps
// Self-checking bench for octant_neighbor_burial: per-octant neighbor tallies and buried flag.
// Drives items through valid/ready with random gaps and stalls; compares each result to a local tally.
// Depends on onb_pkg and the octant_neighbor_burial RTL.
module octant_neighbor_burial_test;

    localparam int COORD_W = 17;
    localparam int CFG_W   = 17;
    localparam int LIMIT   = 500000;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        logic [onb_pkg::OCTANTS-1:0][onb_pkg::COUNT_W-1:0] cnt;
        logic                                              buried;
    } tally_t;

    class octant_tally;
        coord_t                       cx, cy, cz;
        logic [onb_pkg::CUTOFF_W-1:0] cut;
        onb_pkg::count_t              counts [onb_pkg::OCTANTS];
        tally_t                       pending [$];
        int                           errors;

        function new();
            cx = '0;
            cy = '0;
            cz = '0;
            cut = onb_pkg::CUTOFF_RESET;
            errors = 0;
            foreach (counts[i]) counts[i] = '0;
        endfunction

        function void set_reg(onb_pkg::cfg_reg_t idx, logic [CFG_W-1:0] data);
            case (idx)
                onb_pkg::REG_CENTER_X: cx = data[COORD_W-1:0];
                onb_pkg::REG_CENTER_Y: cy = data[COORD_W-1:0];
                onb_pkg::REG_CENTER_Z: cz = data[COORD_W-1:0];
                onb_pkg::REG_CUTOFF:   cut = data[onb_pkg::CUTOFF_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_neighbor(coord_t x, coord_t y, coord_t z, logic self, logic last);
            longint dx, dy, dz, d2, lim;
            logic [onb_pkg::OCT_W-1:0] oct;
            tally_t t;
            if (!self) begin
                dx = longint'(x) - longint'(cx);
                dy = longint'(y) - longint'(cy);
                dz = longint'(z) - longint'(cz);
                d2 = dx * dx + dy * dy + dz * dz;
                lim = longint'(cut) * longint'(cut);
                if (d2 < lim) begin
                    // zero difference falls on the negative side
                    oct = {dz > 0, dy > 0, dx > 0};
                    if (counts[oct] != onb_pkg::COUNT_MAX) counts[oct] = counts[oct] + 1'b1;
                end
            end
            if (last) begin
                t.buried = 1'b1;
                for (int i = 0; i < onb_pkg::OCTANTS; i++) begin
                    t.cnt[i] = counts[i];
                    if (counts[i] < onb_pkg::BURIED_MIN) t.buried = 1'b0;
                    counts[i] = '0;
                end
                pending = {pending, t};
            end
        endfunction

        function void check_tally(tally_t got);
            tally_t want;
            if (pending.size() == 0) begin
                $display("%0t: result with none expected, actual %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            for (int i = 0; i < onb_pkg::OCTANTS; i++) begin
                if (got.cnt[i] !== want.cnt[i]) begin
                    $display("%0t: count_oct%0d expected %0d actual %0d",
                             $time, i, want.cnt[i], got.cnt[i]);
                    errors++;
                end
            end
            if (got.buried !== want.buried) begin
                $display("%0t: buried expected %0b actual %0b", $time, want.buried, got.buried);
                errors++;
            end
        endfunction
    endclass

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_wr_en = 1'b0;
    onb_pkg::cfg_reg_t cfg_addr = onb_pkg::REG_CENTER_X;
    logic [CFG_W-1:0]  cfg_wr_data = '0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    coord_t            s_nbr_x = '0;
    coord_t            s_nbr_y = '0;
    coord_t            s_nbr_z = '0;
    logic              s_is_self = 1'b0;
    logic              s_last = 1'b0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    onb_pkg::count_t   m_count_oct0, m_count_oct1, m_count_oct2, m_count_oct3;
    onb_pkg::count_t   m_count_oct4, m_count_oct5, m_count_oct6, m_count_oct7;
    logic              m_buried;

    octant_tally tally;
    int          tx_idle_pct = 24;
    int          rx_idle_pct = 84;
    int          cycles = 0;

    octant_neighbor_burial #(.COORD_WIDTH(COORD_W)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_nbr_x(s_nbr_x), .s_nbr_y(s_nbr_y), .s_nbr_z(s_nbr_z),
        .s_is_self(s_is_self), .s_last(s_last),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_count_oct0(m_count_oct0), .m_count_oct1(m_count_oct1),
        .m_count_oct2(m_count_oct2), .m_count_oct3(m_count_oct3),
        .m_count_oct4(m_count_oct4), .m_count_oct5(m_count_oct5),
        .m_count_oct6(m_count_oct6), .m_count_oct7(m_count_oct7),
        .m_buried(m_buried)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // result side: check on handshake, then pick next ready
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            tally.check_tally(tally_t'({m_count_oct7, m_count_oct6, m_count_oct5, m_count_oct4,
                                        m_count_oct3, m_count_oct2, m_count_oct1, m_count_oct0,
                                        m_buried}));
        end
        m_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    task automatic send_neighbor(input coord_t x, input coord_t y, input coord_t z,
                                 input logic self, input logic last);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_valid   <= 1'b1;
        s_nbr_x   <= x;
        s_nbr_y   <= y;
        s_nbr_z   <= z;
        s_is_self <= self;
        s_last    <= last;
        do @(posedge aclk); while (!s_ready);
        tally.note_neighbor(x, y, z, self, last);
    endtask

    // hold input until every expected result is back, then let the pipeline empty
    task automatic drain();
        s_valid <= 1'b0;
        while (tally.pending.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic program_regs(input logic [CFG_W-1:0] cxv, input logic [CFG_W-1:0] cyv,
                                input logic [CFG_W-1:0] czv, input logic [CFG_W-1:0] cut_raw);
        onb_pkg::cfg_reg_t order [4] = '{onb_pkg::REG_CENTER_X, onb_pkg::REG_CENTER_Y,
                                         onb_pkg::REG_CENTER_Z, onb_pkg::REG_CUTOFF};
        logic [CFG_W-1:0]  vals [4];
        vals = '{cxv, cyv, czv, cut_raw};
        for (int i = 0; i < 4; i++) begin
            cfg_wr_en   <= 1'b1;
            cfg_addr    <= order[i];
            cfg_wr_data <= vals[i];
            @(posedge aclk);
            tally.set_reg(order[i], vals[i]);
        end
        cfg_wr_en <= 1'b0;
    endtask

    function automatic coord_t near(coord_t c, int span);
        if ($urandom_range(5) == 0) return c;
        return COORD_W'(int'(c) + int'($urandom_range(2 * span)) - span);
    endfunction

    // queries of random length; most points near the center, some anywhere
    task automatic run_queries(input int n_items, input int span, input int noise_pct);
        int     sent;
        int     qlen;
        coord_t x, y, z;
        sent = 0;
        while (sent < n_items) begin
            qlen = $urandom_range(1, 24);
            for (int k = 0; k < qlen; k++) begin
                if ($urandom_range(99) < noise_pct) begin
                    x = COORD_W'($urandom);
                    y = COORD_W'($urandom);
                    z = COORD_W'($urandom);
                end else begin
                    x = near(tally.cx, span);
                    y = near(tally.cy, span);
                    z = near(tally.cz, span);
                end
                send_neighbor(x, y, z, $urandom_range(29) == 0, k == qlen - 1);
            end
            sent += qlen;
        end
    endtask

    initial begin
        logic [onb_pkg::CUTOFF_W-1:0] cut;
        tally = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // reset config: every octant twice, zero on the negative side
        for (int o = 0; o < onb_pkg::OCTANTS; o++)
            send_neighbor(COORD_W'(o[0] ? 3 : 0), COORD_W'(o[1] ? 5 : 0),
                          COORD_W'(o[2] ? 7 : 0), 1'b0, 1'b0);
        for (int o = 0; o < onb_pkg::OCTANTS; o++)
            send_neighbor(COORD_W'(o[0] ? 100 : -7), COORD_W'(o[1] ? 200 : -9),
                          COORD_W'(o[2] ? 300 : -11), 1'b0, o == onb_pkg::OCTANTS - 1);
        send_neighbor(COORD_W'(960), '0, '0, 1'b0, 1'b0);      // on the cutoff: drop
        send_neighbor(COORD_W'(959), '0, '0, 1'b0, 1'b0);
        send_neighbor(COORD_W'(-960), '0, '0, 1'b0, 1'b0);
        send_neighbor('0, COORD_W'(-959), '0, 1'b0, 1'b0);
        send_neighbor(COORD_W'(-65536), COORD_W'(-65536), COORD_W'(-65536), 1'b0, 1'b0);
        send_neighbor(COORD_W'(65535), COORD_W'(65535), COORD_W'(65535), 1'b0, 1'b0);
        send_neighbor('0, '0, '0, 1'b1, 1'b1);        // self item closes the query
        drain();

        // zero cutoff: nothing qualifies
        program_regs('0, '0, '0, '0);
        send_neighbor('0, '0, '0, 1'b0, 1'b0);
        send_neighbor(COORD_W'(1), COORD_W'(1), COORD_W'(1), 1'b0, 1'b1);
        drain();

        tx_idle_pct = 24;
        rx_idle_pct = 84;
        cut = onb_pkg::CUTOFF_W'($urandom_range(1, 4000));
        program_regs(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom), {1'b1, cut});
        run_queries(220, int'(cut), 10);
        drain();

        tx_idle_pct = 84;
        rx_idle_pct = 24;
        program_regs(17'h10000, 17'h0FFFF, 17'h10000, 17'h1FFFF);
        run_queries(110, 40000, 10);
        drain();
        program_regs(17'h0FFFF, 17'h10000, 17'h0FFFF, 17'd1);
        run_queries(110, 2, 5);
        drain();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        cut = onb_pkg::CUTOFF_W'($urandom_range(300, 3000));
        program_regs(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom), {1'b0, cut});
        run_queries(110, int'(cut), 10);
        drain();

        if (tally.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
